@@ rtl/core/vac_pkg.sv @@
// Shared types and constants for the virtual axis conditioner.
// No dependencies; imported by vac_axis_upd and virtual_axis_conditioner.
`default_nettype none

package vac_pkg;

    // Value format: signed Q4.15 held in 20 bits
    localparam int VAL_W   = 20;
    localparam int PROD_W  = 53;   // decay product: 21-bit value by 32-bit gain*dt
    localparam int TRIG_W  = 6;    // trigger mask bits
    localparam int CFG_IW  = 3;    // configuration index width
    localparam int CFG_DW  = 16;   // configuration data width

    // Operation codes
    typedef logic [2:0] vac_op_t;
    localparam vac_op_t OP_DIGITAL = 3'd0;
    localparam vac_op_t OP_ANALOG  = 3'd1;
    localparam vac_op_t OP_MOUSE   = 3'd2;
    localparam vac_op_t OP_TICK    = 3'd3;
    localparam vac_op_t OP_CLEAR   = 3'd4;

    // Configuration register indexes
    typedef logic [CFG_IW-1:0] vac_cfg_idx_t;
    localparam vac_cfg_idx_t CFG_RAMP_GAIN    = 3'd0;
    localparam vac_cfg_idx_t CFG_GRAVITY_GAIN = 3'd1;
    localparam vac_cfg_idx_t CFG_DEADZONE     = 3'd2;
    localparam vac_cfg_idx_t CFG_MOUSE_GAIN   = 3'd3;
    localparam vac_cfg_idx_t CFG_TRIGGER_MASK = 3'd4;

    // Per-axis mode flags handed to the update unit
    typedef struct packed {
        logic mouse;
        logic ovr;
        logic pos;
        logic neg;
    } vac_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/vac_axis_upd.sv @@
// Per-axis tick update: decay rounding, ramp, deadzone and clamp.
// Depends on vac_pkg.
`default_nettype none

module vac_axis_upd (
    input  wire logic signed [vac_pkg::VAL_W-1:0]  v,
    input  wire logic signed [vac_pkg::PROD_W-1:0] prod,
    input  wire logic        [vac_pkg::VAL_W-1:0]  step,
    input  wire vac_pkg::vac_flags_t               flags,
    input  wire logic        [14:0]                deadzone,
    input  wire logic                              trig,
    output logic signed      [vac_pkg::VAL_W-1:0]  result
);
    import vac_pkg::*;

    localparam int DEC_W = PROD_W + 1 - 28;   // rounded decay term width
    localparam int SUM_W = DEC_W + 1;

    logic signed [PROD_W:0]     prod_rnd;
    logic signed [DEC_W-1:0]    dec;
    logic signed [SUM_W-1:0]    vsum;
    logic signed [VAL_W-1:0]    vsat;
    logic signed [VAL_W+1:0]    rsum;
    logic signed [VAL_W+1:0]    pre;
    logic signed [VAL_W+1:0]    lo;
    logic signed [VAL_W+1:0]    clamped;

    // Zero a value whose magnitude is within the deadzone
    function automatic logic signed [VAL_W-1:0] dz_apply(
        input logic signed [VAL_W-1:0] x,
        input logic [14:0]             dzv
    );
        logic [VAL_W:0] mag;
        mag = x[VAL_W-1] ? (~{x[VAL_W-1], x} + 1'b1) : {x[VAL_W-1], x};
        if (mag <= {{(VAL_W-14){1'b0}}, dzv})
            return '0;
        return x;
    endfunction

    // Decay: round half up of prod / 2^28, add, saturate to 20 bits
    always_comb
    begin
        prod_rnd = {prod[PROD_W-1], prod} + (PROD_W+1)'(64'd1 << 27);
        dec      = prod_rnd[PROD_W:28];
        vsum     = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v} + {dec[DEC_W-1], dec};
        if (vsum > SUM_W'(524287))
            vsat = VAL_W'(524287);
        else if (vsum < -SUM_W'(524288))
            vsat = VAL_W'(-524288);
        else
            vsat = vsum[VAL_W-1:0];
    end

    // Ramp: add and subtract the step for the held sides
    always_comb
    begin
        rsum = {{2{v[VAL_W-1]}}, v};
        if (flags.pos)
            rsum = rsum + {2'b00, step};
        if (flags.neg)
            rsum = rsum - {2'b00, step};
    end

    // Select ramp or decay, then clamp to the axis range
    always_comb
    begin
        logic signed [VAL_W-1:0] dzd;
        dzd = dz_apply(vsat, deadzone);
        pre = (flags.pos || flags.neg) ? rsum : {{2{dzd[VAL_W-1]}}, dzd};
        lo  = trig ? '0 : -(VAL_W+2)'(32768);
        if (pre < lo)
            clamped = lo;
        else if (pre > (VAL_W+2)'(32768))
            clamped = (VAL_W+2)'(32768);
        else
            clamped = pre;
    end

    // Mouse-driven axes hold, overridden axes only see the deadzone
    always_comb
    begin
        priority if (flags.mouse)
            result = v;
        else if (flags.ovr)
            result = dz_apply(v, deadzone);
        else
            result = clamped[VAL_W-1:0];
    end

endmodule

`default_nettype wire

@@ rtl/core/virtual_axis_conditioner.sv @@
// Virtual axis conditioner top level: event handling, value memory, tick walk.
// Depends on vac_pkg and vac_axis_upd.
`default_nettype none

//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    op, axis, direction, pressed, sample, delta_time
//  result    out        out_valid / out_stall  out_axis, axis_value, last
//  config    in         cfg_we                 cfg_index, cfg_data
//
// Digital, analog and clear items complete when accepted; a mouse item then
// writes its value in S_MOUSE. A tick loads its step and gravity*dt when accepted,
// then walks the axes, each through S_READ (memory read), S_MUL (decay multiply)
// and S_CALC (update and write-back); S_CALC waits while out_stall holds the result
// register. The next axis starts while the previous result is still held.
// Reset clears flags, the value memory valid bits (all values read as zero)
// and restores configuration defaults; no clearing pass is needed.

module virtual_axis_conditioner #(
    parameter int NUM_AXES = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input items
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    op,
    input  wire logic [2:0]                    axis,
    input  wire logic                          direction,
    input  wire logic                          pressed,
    input  wire logic signed [15:0]            sample,
    input  wire logic [15:0]                   delta_time,
    // result items
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         out_axis,
    output logic signed [vac_pkg::VAL_W-1:0]   axis_value,
    output logic                               last,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [vac_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [vac_pkg::CFG_DW-1:0]    cfg_data
);
    import vac_pkg::*;

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOUSE,
        S_READ,
        S_MUL,
        S_CALC
    } state_t;

    // control state
    state_t                 state_reg, state_next;
    logic [AW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]          ax_reg, ax_next;
    logic [NUM_AXES-1:0]    pos_reg, pos_next;
    logic [NUM_AXES-1:0]    neg_reg, neg_next;
    logic [NUM_AXES-1:0]    ovr_reg, ovr_next;
    logic [NUM_AXES-1:0]    mouse_reg, mouse_next;
    logic [NUM_AXES-1:0]    vld_reg, vld_next;
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             out_axis_reg, out_axis_next;
    logic signed [VAL_W-1:0] axis_value_reg, axis_value_next;
    logic                   last_reg, last_next;

    // configuration registers
    logic [15:0]            ramp_gain_reg;
    logic [15:0]            gravity_gain_reg;
    logic [14:0]            deadzone_reg;
    logic [15:0]            mouse_gain_reg;
    logic [TRIG_W-1:0]      trig_mask_reg;

    // datapath registers
    logic [VAL_W-1:0]        step_reg, step_next;
    logic [31:0]             gdt_reg, gdt_next;
    logic signed [32:0]      mprod_reg, mprod_next;
    logic signed [VAL_W-1:0] v_reg, v_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [VAL_W-1:0] rdata_reg;

    // value memory
    logic signed [VAL_W-1:0] mem [NUM_AXES];
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;

    logic                    in_acc;
    logic                    ax_ok;
    logic [AW-1:0]           ax_idx;
    logic                    out_free;
    logic [NUM_AXES-1:0]     trig_vec;
    logic signed [VAL_W-1:0] upd_result;
    vac_flags_t              upd_flags;
    logic [32:0]             rp;
    logic signed [33:0]      mrnd;
    logic signed [32:0]      mhalf;
    logic signed [VAL_W-1:0] msat;
    logic signed [VAL_W-1:0] vm;
    logic signed [VAL_W:0]   negv;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_axis   = out_axis_reg;
    assign axis_value = axis_value_reg;
    assign last       = last_reg;

    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign ax_ok    = ({29'd0, axis} < 32'(NUM_AXES));
    assign ax_idx   = AW'(axis);
    assign out_free = !out_valid_reg || !out_stall;

    // trigger flags: only the first six axes have a mask bit
    for (genvar j = 0; j < NUM_AXES; j++)
    begin : g_trig
        if (j < TRIG_W)
        begin : g_bit
            assign trig_vec[j] = trig_mask_reg[j];
        end
        else
        begin : g_none
            assign trig_vec[j] = 1'b0;
        end
    end

    // tick constants: ramp step and gravity*dt
    assign rp = 33'(ramp_gain_reg) * 33'(delta_time) + 33'd4096;

    // mouse value: halve with round half up, saturate
    always_comb
    begin
        mrnd  = {mprod_reg[32], mprod_reg} + 34'sd1;
        mhalf = mrnd[33:1];
        if (mhalf > 33'sd524287)
            msat = VAL_W'(524287);
        else if (mhalf < -33'sd524288)
            msat = VAL_W'(-524288);
        else
            msat = mhalf[VAL_W-1:0];
    end

    // read data masked by valid bit, negated for the decay product
    assign vm   = vld_reg[cnt_reg] ? rdata_reg : '0;
    assign negv = -{vm[VAL_W-1], vm};

    assign upd_flags = '{mouse: mouse_reg[cnt_reg], ovr: ovr_reg[cnt_reg],
                         pos: pos_reg[cnt_reg], neg: neg_reg[cnt_reg]};

    vac_axis_upd u_upd (
        .v        (v_reg),
        .prod     (prod_reg),
        .step     (step_reg),
        .flags    (upd_flags),
        .deadzone (deadzone_reg),
        .trig     (trig_vec[cnt_reg]),
        .result   (upd_result)
    );

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ax_next         = ax_reg;
        pos_next        = pos_reg;
        neg_next        = neg_reg;
        ovr_next        = ovr_reg;
        mouse_next      = mouse_reg;
        vld_next        = vld_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_axis_next   = out_axis_reg;
        axis_value_next = axis_value_reg;
        last_next       = last_reg;
        step_next       = step_reg;
        gdt_next        = gdt_reg;
        mprod_next      = mprod_reg;
        v_next          = v_reg;
        prod_next       = prod_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg;
        mem_wdata       = upd_result;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (op)
                        OP_DIGITAL:
                        begin
                            if (ax_ok)
                            begin
                                if (direction)
                                    neg_next[ax_idx] = pressed;
                                else
                                    pos_next[ax_idx] = pressed;
                                ovr_next[ax_idx] = 1'b0;
                            end
                        end
                        OP_ANALOG:
                        begin
                            if (ax_ok)
                            begin
                                mem_we             = 1'b1;
                                mem_waddr          = ax_idx;
                                mem_wdata          = VAL_W'(sample);
                                vld_next[ax_idx]   = 1'b1;
                                ovr_next[ax_idx]   = 1'b1;
                                mouse_next[ax_idx] = 1'b0;
                            end
                        end
                        OP_MOUSE:
                        begin
                            if (ax_ok && (sample != 16'sd0))
                            begin
                                mprod_next         = 33'(sample) *
                                                     $signed(33'(mouse_gain_reg));
                                ax_next            = ax_idx;
                                ovr_next[ax_idx]   = 1'b1;
                                mouse_next[ax_idx] = 1'b1;
                                state_next         = S_MOUSE;
                            end
                        end
                        OP_TICK:
                        begin
                            step_next  = rp[32:13];
                            gdt_next   = 32'(gravity_gain_reg) * 32'(delta_time);
                            cnt_next   = '0;
                            state_next = S_READ;
                        end
                        OP_CLEAR:
                        begin
                            // cleared entries read back as zero
                            vld_next = vld_reg & ~mouse_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MOUSE:
            begin
                mem_we           = 1'b1;
                mem_waddr        = ax_reg;
                mem_wdata        = msat;
                vld_next[ax_reg] = 1'b1;
                state_next       = S_IDLE;
            end
            S_READ:
            begin
                // memory read of entry cnt_reg lands in rdata_reg
                state_next = S_MUL;
            end
            S_MUL:
            begin
                v_next     = vm;
                prod_next  = PROD_W'(negv) * $signed(PROD_W'(gdt_reg));
                state_next = S_CALC;
            end
            S_CALC:
            begin
                // write back and report once the result register is free
                if (out_free)
                begin
                    mem_we            = 1'b1;
                    vld_next[cnt_reg] = 1'b1;
                    out_valid_next    = 1'b1;
                    out_axis_next     = 3'(cnt_reg);
                    axis_value_next   = upd_result;
                    last_next         = (cnt_reg == AW'(NUM_AXES - 1));
                    if (cnt_reg == AW'(NUM_AXES - 1))
                        state_next = S_IDLE;
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            ax_reg         <= '0;
            pos_reg        <= '0;
            neg_reg        <= '0;
            ovr_reg        <= '0;
            mouse_reg      <= '0;
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_axis_reg   <= '0;
            axis_value_reg <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ax_reg         <= ax_next;
            pos_reg        <= pos_next;
            neg_reg        <= neg_next;
            ovr_reg        <= ovr_next;
            mouse_reg      <= mouse_next;
            vld_reg        <= vld_next;
            out_valid_reg  <= out_valid_next;
            out_axis_reg   <= out_axis_next;
            axis_value_reg <= axis_value_next;
            last_reg       <= last_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_gain_reg    <= 16'd4096;
            gravity_gain_reg <= 16'd4096;
            deadzone_reg     <= 15'd2949;
            mouse_gain_reg   <= 16'd5243;
            trig_mask_reg    <= 6'd48;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RAMP_GAIN:    ramp_gain_reg    <= cfg_data;
                CFG_GRAVITY_GAIN: gravity_gain_reg <= cfg_data;
                CFG_DEADZONE:     deadzone_reg     <= cfg_data[14:0];
                CFG_MOUSE_GAIN:   mouse_gain_reg   <= cfg_data;
                CFG_TRIGGER_MASK: trig_mask_reg    <= cfg_data[TRIG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        gdt_reg   <= gdt_next;
        mprod_reg <= mprod_next;
        v_reg     <= v_next;
        prod_reg  <= prod_next;
    end

    // value memory: one write port, registered read at the tick counter.
    // Each axis is read, then written, before the next access, so no overlap.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[cnt_reg];
    end

    // the final result of a tick carries the last axis index
    a_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> out_axis_reg == 3'(NUM_AXES - 1))
        else $error("last flag on wrong axis");

    // events other than a tick never raise a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (op != OP_TICK) |=> !$rose(out_valid_reg))
        else $error("result from a non-tick item");

    // a tick holds off input while it walks the axes
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (op == OP_TICK) |=> in_stall && (cnt_reg == '0))
        else $error("tick did not start its walk");

    // the axis counter stays within the memory
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> {{(32-AW){1'b0}}, cnt_reg} < 32'(NUM_AXES))
        else $error("axis counter out of range");

endmodule

`default_nettype wire
